[hw/rtl/fdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fault debounce qualifier package
// Shared qualification state codes, register indexes and the step settings
// record passed from the register bank to the qualification logic.
// ----------------------------------------------------------------------------
package fdq_pkg;

    // Width of the step and level registers.
    localparam int CFG_STEP_BITS = 16;
    // Width of the configuration write data and register index.
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;
    // Fixed widths of the result fields and of the mask fields taken from the configuration data.
    localparam int OUT_COUNT_BITS = 16;
    localparam int OUT_ACTION_BITS = 32;
    localparam int OUT_EVENT_BITS = 8;
    localparam int CFG_MASK_BITS = 32;
    localparam int CFG_EVENT_BITS = 8;

    // Qualification state codes.
    localparam logic [1:0] QS_NONE      = 2'd0;
    localparam logic [1:0] QS_DETECTED  = 2'd1;
    localparam logic [1:0] QS_CONFIRMED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_INC_STEP       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEC_STEP       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_COUNT      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESTORE_IGN    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DETECT_ACTION  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIRM_ACTION = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESTORE_ACTION = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EVENT_MASK     = 3'd7;

    // Debounce step settings.
    typedef struct packed {
        logic [CFG_STEP_BITS-1:0] inc_step;
        logic [CFG_STEP_BITS-1:0] dec_step;
        logic [CFG_STEP_BITS-1:0] max_count;
        logic                     restore_at_ignition;
    } fdq_steps_t;

endpackage
`default_nettype wire

[hw/rtl/fault_debounce_qualifier_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fault debounce qualifier
// Qualifies one fault channel per tick with a counter-based debounce and a
// three-state machine (no error, detected, confirmed).
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_ channel is one tick: the raw fault bit and a suppress
//   bit. Each tick produces exactly one word on the m_ channel holding the
//   state after the tick, the debounce counter and the action and event bits
//   raised by that tick.
//   An accepted word lands in the input register; once the result register
//   is free the tick is evaluated and written into the result register, from
//   which the result is offered and taken when the receiver is ready. One
//   word is accepted per cycle while the receiver takes the results; the rate
//   is set by the single state and counter update.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; s_tready then drops until the
//   result is taken.
//   Reset clears both registers, sets the state to no error, the counter to
//   zero and the configuration registers to their defaults.
//   Configuration is written through cfg_we, cfg_index and cfg_data; the user
//   must write it only while no tick is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module fault_debounce_qualifier_top #(
    parameter int COUNT_BITS  = 16,
    parameter int ACTION_BITS = 32,
    parameter int EVENT_BITS  = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port.
    input  wire logic                                cfg_we,
    input  wire logic [fdq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [fdq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Input ticks.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [0] fault_seen, [1] suppressed
    // Results.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] fault_state, [17:2] debounce_count, [49:18] action_flags, [57:50] event_flags
    output logic [63:0]                              m_tdata
);
    import fdq_pkg::*;

    // Configuration registers.
    fdq_steps_t             steps_reg;
    logic [ACTION_BITS-1:0] detect_mask_reg;
    logic [ACTION_BITS-1:0] confirm_mask_reg;
    logic [ACTION_BITS-1:0] restore_mask_reg;
    logic [EVENT_BITS-1:0]  event_mask_reg;

    // Input register.
    logic                   in_vld_reg;
    logic                   fault_reg;
    logic                   supp_reg;

    // Qualification state.
    logic [1:0]             qual_state_reg;
    logic [COUNT_BITS-1:0]  counter_reg;

    // Result register.
    logic                   out_vld_reg;
    logic [1:0]             out_state_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [ACTION_BITS-1:0] out_action_reg;
    logic [EVENT_BITS-1:0]  out_event_reg;

    logic [1:0]             qual_state_next;
    logic [COUNT_BITS-1:0]  counter_next;
    logic [ACTION_BITS-1:0] action_next;
    logic [EVENT_BITS-1:0]  event_next;
    logic                   out_free;
    logic                   adv;

    // Handshake: the result register frees when empty or being taken.
    assign out_free = !out_vld_reg || m_tready;
    assign adv      = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    // Configuration register bank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg.inc_step            <= CFG_STEP_BITS'(1);
            steps_reg.dec_step            <= CFG_STEP_BITS'(1);
            steps_reg.max_count           <= CFG_STEP_BITS'(10);
            steps_reg.restore_at_ignition <= 1'b0;
            detect_mask_reg               <= '0;
            confirm_mask_reg              <= '0;
            restore_mask_reg              <= '0;
            event_mask_reg                <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INC_STEP:       steps_reg.inc_step <= cfg_data[CFG_STEP_BITS-1:0];
                REG_DEC_STEP:       steps_reg.dec_step <= cfg_data[CFG_STEP_BITS-1:0];
                REG_MAX_COUNT:      steps_reg.max_count <= cfg_data[CFG_STEP_BITS-1:0];
                REG_RESTORE_IGN:    steps_reg.restore_at_ignition <= cfg_data[0];
                REG_DETECT_ACTION:  detect_mask_reg <= ACTION_BITS'(cfg_data[CFG_MASK_BITS-1:0]);
                REG_CONFIRM_ACTION: confirm_mask_reg <= ACTION_BITS'(cfg_data[CFG_MASK_BITS-1:0]);
                REG_RESTORE_ACTION: restore_mask_reg <= ACTION_BITS'(cfg_data[CFG_MASK_BITS-1:0]);
                REG_EVENT_MASK:     event_mask_reg <= EVENT_BITS'(cfg_data[CFG_EVENT_BITS-1:0]);
                default:            event_mask_reg <= event_mask_reg;
            endcase
        end
    end

    // Input register: takes a word whenever it is empty or moving on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            fault_reg <= s_tdata[0];
            supp_reg  <= s_tdata[1];
        end
    end

    // Tick evaluation.
    fdq_step #(
        .COUNT_BITS  (COUNT_BITS),
        .ACTION_BITS (ACTION_BITS),
        .EVENT_BITS  (EVENT_BITS)
    ) u_step (
        .qual_state          (qual_state_reg),
        .counter             (counter_reg),
        .fault_seen          (fault_reg),
        .suppressed          (supp_reg),
        .steps               (steps_reg),
        .detect_action_mask  (detect_mask_reg),
        .confirm_action_mask (confirm_mask_reg),
        .restore_action_mask (restore_mask_reg),
        .event_mask          (event_mask_reg),
        .qual_state_next     (qual_state_next),
        .counter_next        (counter_next),
        .action_flags        (action_next),
        .event_flags         (event_next)
    );

    // State and result valid update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qual_state_reg <= QS_NONE;
            counter_reg    <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (adv) begin
                qual_state_reg <= qual_state_next;
                counter_reg    <= counter_next;
            end
            if (out_free) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_state_reg  <= qual_state_next;
            out_count_reg  <= counter_next;
            out_action_reg <= action_next;
            out_event_reg  <= event_next;
        end
    end

    // Output packing.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0,
                       OUT_EVENT_BITS'(out_event_reg),
                       OUT_ACTION_BITS'(out_action_reg),
                       OUT_COUNT_BITS'(out_count_reg),
                       out_state_reg};

`ifndef SYNTH
    // The counter is zero whenever the channel is in the no error state.
    a_none_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (qual_state_reg == QS_NONE) |-> (counter_reg == '0))
        else $error("counter nonzero in no error state");

    // Event bits are only reported together with a confirmed state.
    a_event_confirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[57:50] != 8'd0)) |-> (m_tdata[1:0] == QS_CONFIRMED))
        else $error("event bits outside confirmed state");

    // State only moves when a tick is evaluated.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !adv) |=> ($stable(counter_reg) && $stable(qual_state_reg)))
        else $error("state changed without a tick");

    // A full input stage behind a stalled result blocks new words.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");
`endif

endmodule
`default_nettype wire

[hw/rtl/fdq_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Fault debounce qualifier step logic
// Combinational next-state logic for one tick: state machine, debounce
// counter update and the action and event bits raised by the tick.
// ----------------------------------------------------------------------------
module fdq_step #(
    parameter int COUNT_BITS  = 16,
    parameter int ACTION_BITS = 32,
    parameter int EVENT_BITS  = 8
) (
    input  wire logic [1:0]             qual_state,
    input  wire logic [COUNT_BITS-1:0]  counter,
    input  wire logic                   fault_seen,
    input  wire logic                   suppressed,
    input  wire fdq_pkg::fdq_steps_t    steps,
    input  wire logic [ACTION_BITS-1:0] detect_action_mask,
    input  wire logic [ACTION_BITS-1:0] confirm_action_mask,
    input  wire logic [ACTION_BITS-1:0] restore_action_mask,
    input  wire logic [EVENT_BITS-1:0]  event_mask,
    output logic      [1:0]             qual_state_next,
    output logic      [COUNT_BITS-1:0]  counter_next,
    output logic      [ACTION_BITS-1:0] action_flags,
    output logic      [EVENT_BITS-1:0]  event_flags
);
    import fdq_pkg::*;

    // Comparisons are made one bit wider than either operand so sums never wrap.
    localparam int SUM_BITS = ((COUNT_BITS > CFG_STEP_BITS) ? COUNT_BITS : CFG_STEP_BITS) + 1;

    logic [SUM_BITS-1:0] cnt_w;
    logic [SUM_BITS-1:0] inc_w;
    logic [SUM_BITS-1:0] dec_w;
    logic [SUM_BITS-1:0] max_w;
    logic [SUM_BITS-1:0] sum_w;
    logic [SUM_BITS-1:0] diff_w;
    logic                reach_max;
    logic                at_floor;
    logic                latch;

    // Widened operands and the shared add and subtract.
    assign cnt_w     = SUM_BITS'(counter);
    assign inc_w     = SUM_BITS'(steps.inc_step);
    assign dec_w     = SUM_BITS'(steps.dec_step);
    assign max_w     = SUM_BITS'(steps.max_count);
    assign sum_w     = cnt_w + inc_w;
    assign diff_w    = cnt_w - dec_w;
    assign reach_max = (sum_w >= max_w);
    assign at_floor  = (cnt_w <= dec_w);
    assign latch     = steps.restore_at_ignition;

    // State machine for one tick.
    always_comb begin
        qual_state_next = qual_state;
        counter_next    = counter;
        action_flags    = '0;
        event_flags     = '0;
        unique case (qual_state)
            QS_NONE: begin
                if (!suppressed && fault_seen) begin
                    action_flags = detect_action_mask;
                    qual_state_next = QS_DETECTED;
                    if (inc_w < max_w) begin
                        counter_next = COUNT_BITS'(inc_w);
                    end else if (reach_max) begin
                        // The increment alone reaches the level: confirm at once.
                        counter_next    = COUNT_BITS'(max_w);
                        qual_state_next = QS_CONFIRMED;
                        action_flags    = detect_action_mask | confirm_action_mask;
                        event_flags     = event_mask;
                    end else begin
                        counter_next = COUNT_BITS'(sum_w);
                    end
                end
            end
            QS_DETECTED: begin
                if (!suppressed) begin
                    if (fault_seen) begin
                        if (reach_max) begin
                            counter_next    = COUNT_BITS'(max_w);
                            qual_state_next = QS_CONFIRMED;
                            action_flags    = confirm_action_mask;
                            event_flags     = event_mask;
                        end else begin
                            counter_next = COUNT_BITS'(sum_w);
                        end
                    end else if (at_floor) begin
                        counter_next    = '0;
                        qual_state_next = QS_NONE;
                    end else begin
                        counter_next = COUNT_BITS'(diff_w);
                    end
                end
            end
            QS_CONFIRMED: begin
                if (fault_seen || latch) begin
                    // The counter is only written when it reaches the level.
                    if (!latch && reach_max) begin
                        counter_next = COUNT_BITS'(max_w);
                    end
                    action_flags = confirm_action_mask;
                    event_flags  = event_mask;
                end else if (at_floor) begin
                    qual_state_next = QS_NONE;
                    counter_next    = '0;
                    action_flags    = restore_action_mask;
                end else begin
                    counter_next = COUNT_BITS'(diff_w);
                    action_flags = confirm_action_mask;
                    event_flags  = event_mask;
                end
            end
            default: begin
                // Unused code: state and counter are held, nothing is raised.
                qual_state_next = qual_state;
            end
        endcase
    end

endmodule
`default_nettype wire
